FILE: rtl/signed_int_to_decimal_ascii_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII core
// Shared helpers that write clocked properties on clk with rst as disable.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sida: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sida: next-cycle check failed");

`endif

FILE: rtl/sida_pkg.sv
// ---------------------------------------------------------------------------
// sida_pkg
// Types and constants shared by the decimal ASCII conversion core.
// ---------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
  localparam logic [3:0]  SIZE_CAP    = 4'd12;
  localparam logic [3:0]  MIN_SIZE    = 4'd2;
  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the divide-by-ten unit.
  typedef struct packed {
    logic init;
    logic mul;
    logic advance;
  } div_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sida_div10.sv
// ---------------------------------------------------------------------------
// sida_div10
// Shared divide-by-ten unit: reciprocal multiply, then quotient and digit.
// ---------------------------------------------------------------------------
`default_nettype none

module sida_div10
  import sida_pkg::*;
(
  input  wire logic        clk,
  input  wire div_ctrl_t   ctrl,
  input  wire logic [31:0] init_value,
  output logic [3:0]       digit,
  output logic             quot_zero
);

  logic [31:0] mag;
  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] quot_ext;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;

  // The product is registered so the subtract below starts from a flop.
  assign quot     = prod[63:RECIP_SHIFT];
  assign quot_ext = {3'b000, quot};
  assign quot_x10 = {quot_ext[28:0], 3'b000} + {quot_ext[30:0], 1'b0};
  assign rem_full = mag - quot_x10;
  assign digit    = rem_full[3:0];
  assign quot_zero = (quot == 29'd0);

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      mag <= init_value;
    end else if (ctrl.advance) begin
      mag <= quot_ext;
    end
    if (ctrl.mul) begin
      prod <= 64'(mag) * 64'(RECIP10);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sida_charbuf.sv
// ---------------------------------------------------------------------------
// sida_charbuf
// Small character store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module sida_charbuf #(
  parameter int DEPTH = 11,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  // The read data register doubles as the character output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii_core.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit number into a stream of decimal ASCII characters.
// ---------------------------------------------------------------------------
// Usage:
//   A word (number, buffer_size) is taken at a rising edge where start is
//   high and busy is low. buffer_size counts one place for a terminator that
//   is never sent and saturates at 12; a size below 2 is accepted but yields
//   no characters and leaves busy low.
//   Each character leaves on character/last with strobe high for exactly one
//   cycle, most significant first, last set on the final one. The receiver
//   cannot stall the stream, so no back-pressure exists on the output side.
// Sequence:
//   The shared divide-by-ten unit handles each digit as a registered
//   reciprocal multiply (ST_MUL) and then the subtract (ST_REM), an
//   optional ST_SIGN state writes the sign, and ST_EMIT then feeds the
//   registered store read, one character after another. The first
//   character is strobed once the sequencer has entered ST_EMIT and the
//   strobe register has taken it up; the final character is strobed in
//   the first cycle in which busy is low.
// Reset:
//   rst returns the sequencer to idle and clears strobe; no pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_core_defines.svh"

module signed_int_to_decimal_ascii_core
  import sida_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] number,
  input  wire logic        [3:0]  buffer_size,
  output logic                    strobe,
  output logic             [7:0]  character,
  output logic                    last
);

  // The store holds up to MAX_DIGITS digits plus a sign.
  localparam int SLOTS = MAX_DIGITS + 1;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int CMPW  = (CW > 4) ? CW : 4;

  state_t state, state_next;

  // Sequencer registers.
  logic [CW-1:0] n, n_next;
  logic [3:0]    room, room_next;
  logic          neg, neg_next;

  // Output register inputs.
  logic          strobe_next;
  logic          last_next;

  // Datapath controls.
  div_ctrl_t     div_ctrl;
  logic [3:0]    digit;
  logic          quot_zero;
  logic          buf_we;
  logic [7:0]    buf_wdata;
  logic [7:0]    buf_rdata;
  logic [AW-1:0] buf_waddr;
  logic [AW-1:0] buf_raddr;

  // Input decode for the accept cycle.
  logic          accept;
  logic          size_ok;
  logic [3:0]    size_sat;
  logic [31:0]   num_u;
  logic [31:0]   mag_in;

  // Count compares are done at a common width.
  logic [CW-1:0]   n_inc;
  logic [CW-1:0]   n_dec;
  logic [CMPW-1:0] n_inc_cmp;
  logic [CMPW-1:0] n_cmp;
  logic [CMPW-1:0] room_cmp;
  logic            more_digits;
  logic            sign_after_digit;
  logic            sign_fits;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign size_sat = (buffer_size > SIZE_CAP) ? SIZE_CAP : buffer_size;
  assign size_ok  = (buffer_size >= MIN_SIZE);
  assign num_u    = unsigned'(number);
  // Two's complement negate; the minimum integer maps onto magnitude 2^31.
  assign mag_in   = number[31] ? (32'd0 - num_u) : num_u;

  assign n_inc     = n + CW'(1);
  assign n_dec     = n - CW'(1);
  assign n_inc_cmp = CMPW'(n_inc);
  assign n_cmp     = CMPW'(n);
  assign room_cmp  = CMPW'(room);

  // After storing the current digit, go on while the quotient is nonzero and
  // neither the caller's room nor the digit cap is used up.
  assign more_digits = !quot_zero && (n_inc_cmp < room_cmp) &&
                       (n_inc_cmp < CMPW'(MAX_DIGITS));
  assign sign_after_digit = neg && (n_inc_cmp < room_cmp);
  assign sign_fits = (n_cmp < room_cmp);

  sida_div10 u_div10 (
    .clk        (clk),
    .ctrl       (div_ctrl),
    .init_value (mag_in),
    .digit      (digit),
    .quot_zero  (quot_zero)
  );

  sida_charbuf #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_charbuf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  assign buf_waddr = n[AW-1:0];
  // Characters are read back from the top of the store downward.
  assign buf_raddr = n_dec[AW-1:0];
  // The registered store read lines up with strobe and last.
  assign character = buf_rdata;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && size_ok) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_REM;
      end
      ST_REM: begin
        if (more_digits) begin
          state_next = ST_MUL;
        end else if (sign_after_digit) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SIGN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (n == CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output and datapath control logic.
  always_comb begin
    n_next         = n;
    room_next      = room;
    neg_next       = neg;
    div_ctrl       = '0;
    buf_we         = 1'b0;
    buf_wdata      = CHAR_ZERO;
    strobe_next    = 1'b0;
    last_next      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && size_ok) begin
          div_ctrl.init = 1'b1;
          n_next        = '0;
          room_next     = size_sat - 4'd1;
          neg_next      = number[31];
        end
      end
      ST_MUL: begin
        div_ctrl.mul = 1'b1;
      end
      ST_REM: begin
        div_ctrl.advance = 1'b1;
        buf_we           = 1'b1;
        buf_wdata        = CHAR_ZERO + {4'd0, digit};
        n_next           = n_inc;
      end
      ST_SIGN: begin
        buf_we    = sign_fits;
        buf_wdata = CHAR_MINUS;
        n_next    = n_inc;
      end
      ST_EMIT: begin
        strobe_next = 1'b1;
        last_next   = (n == CW'(1));
        n_next      = n_dec;
      end
      default: begin
        n_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      n      <= '0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      n      <= n_next;
    end
    room      <= room_next;
    neg       <= neg_next;
    last      <= last_next;
  end

  // The final read of the store must come out flagged as the last word.
  `SIDA_ASSERT_NEXT(a_last_follows_final_read, (state == ST_EMIT) && (n == CW'(1)),
                    strobe && last)
  // A refused word never starts a conversion or produces output.
  `SIDA_ASSERT_NEXT(a_refused_word_is_silent, accept && !size_ok, !busy && !strobe)
  // More words of the same number still have to come while busy.
  `SIDA_ASSERT_NOW(a_more_words_while_busy, strobe && !last, busy)
  // The digit subtract always follows a multiply cycle.
  `SIDA_ASSERT_NOW(a_rem_after_mul, state == ST_REM, $past(state == ST_MUL))

endmodule

`default_nettype wire
